/* rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, status codes and lead byte tables for the UTF-8 to UTF-16
// decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int UnitW = 16;
  localparam int StatW = 3;
  localparam int AccW  = 31;
  localparam int LenW  = 3;

  localparam logic [StatW-1:0] ST_UNIT       = 3'd0;
  localparam logic [StatW-1:0] ST_END        = 3'd1;
  localparam logic [StatW-1:0] ST_BAD_LEAD   = 3'd2;
  localparam logic [StatW-1:0] ST_BAD_CONT   = 3'd3;
  localparam logic [StatW-1:0] ST_UNMAPPABLE = 3'd4;

  localparam logic [AccW-1:0] CP_SURR_LO = 31'h0000_D800;
  localparam logic [AccW-1:0] CP_SURR_HI = 31'h0000_E000;
  localparam logic [AccW-1:0] CP_BMP_MAX = 31'h0000_FFFF;
  localparam logic [AccW-1:0] CP_SUP_MIN = 31'h0001_0000;
  localparam logic [AccW-1:0] CP_SUP_MAX = 31'h0010_FFFF;
  localparam logic [AccW-1:0] CP_BOM     = 31'h0000_FEFF;
  localparam logic [5:0]      HI_SURR    = 6'b110110;   // 0xD800 >> 10
  localparam logic [5:0]      LO_SURR    = 6'b110111;   // 0xDC00 >> 10

  // Decoded results of one byte: 0, 1 or 2 words
  typedef struct packed {
    logic [1:0]       cnt;
    logic [UnitW-1:0] unit0;
    logic [StatW-1:0] stat0;
    logic [UnitW-1:0] unit1;   // low surrogate, always status unit
  } dec_res_t;

  // Sequence length from lead byte class; 0 marks a bad lead
  function automatic logic [LenW-1:0] lead_len(input logic [7:0] b);
    logic [LenW-1:0] len;
    case (b) inside
      [8'h00:8'h7F]: len = 3'd1;
      [8'hC0:8'hDF]: len = 3'd2;
      [8'hE0:8'hEF]: len = 3'd3;
      [8'hF0:8'hF7]: len = 3'd4;
      [8'hF8:8'hFB]: len = 3'd5;
      [8'hFC:8'hFD]: len = 3'd6;
      default:       len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [LenW-1:0] len);
    logic [7:0] m;
    case (len)
      3'd1:    m = 8'h7F;
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

/* rtl/u8u16_dec.sv */
// ----------------------------------------------------------------------------
// u8u16_dec
// Sequence state and per-byte decode: accumulates code point bits and maps a
// finished code point onto zero, one or two result words.
// ----------------------------------------------------------------------------
module u8u16_dec
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,       // byte in in_byte is consumed this cycle
  input  logic [7:0] in_byte,
  output dec_res_t   res
);

  logic [LenW-1:0] rem_r, rem_nxt;
  logic [LenW-1:0] seq_r, seq_nxt;
  logic [AccW-1:0] acc_r, acc_nxt;

  logic            is_lead;
  logic            cont_ok;
  logic [LenW-1:0] len;
  logic [LenW-1:0] seq_eff;
  logic [AccW-1:0] cand;
  logic            done;
  logic [19:0]     sup_off;
  logic [20:0]     sup_diff;

  assign is_lead  = (rem_r == '0);
  assign cont_ok  = (in_byte[7:6] == 2'b10);
  assign len      = lead_len(in_byte);
  assign seq_eff  = is_lead ? len : seq_r;
  assign cand     = is_lead ? {23'd0, in_byte & lead_mask(len)}
                            : {acc_r[AccW-7:0], in_byte[5:0]};
  assign done     = is_lead ? ((in_byte != 8'h00) && (len == 3'd1))
                            : (cont_ok && (rem_r == 3'd1));
  assign sup_diff = cand[20:0] - CP_SUP_MIN[20:0];
  assign sup_off  = sup_diff[19:0];

  always_comb begin
    res     = '0;
    rem_nxt = rem_r;
    seq_nxt = seq_r;
    acc_nxt = acc_r;
    if (is_lead && (in_byte == 8'h00)) begin
      res.cnt   = 2'd1;
      res.stat0 = ST_END;
    end else if (is_lead && (len == '0)) begin
      res.cnt   = 2'd1;
      res.stat0 = ST_BAD_LEAD;
    end else if (!is_lead && !cont_ok) begin
      res.cnt   = 2'd1;
      res.stat0 = ST_BAD_CONT;
      rem_nxt   = '0;
      seq_nxt   = '0;
      acc_nxt   = '0;
    end else if (done) begin
      rem_nxt = '0;
      seq_nxt = '0;
      acc_nxt = '0;
      if ((seq_eff == 3'd3) && (cand == CP_BOM)) begin
        res.cnt = 2'd0;             // byte order mark is dropped
      end else if ((cand < CP_SURR_LO) ||
                   ((cand >= CP_SURR_HI) && (cand <= CP_BMP_MAX))) begin
        res.cnt   = 2'd1;
        res.unit0 = cand[UnitW-1:0];
        res.stat0 = ST_UNIT;
      end else if ((cand >= CP_SUP_MIN) && (cand <= CP_SUP_MAX)) begin
        res.cnt   = 2'd2;
        res.unit0 = {HI_SURR, sup_off[19:10]};
        res.stat0 = ST_UNIT;
        res.unit1 = {LO_SURR, sup_off[9:0]};
      end else begin
        res.cnt   = 2'd1;
        res.stat0 = ST_UNMAPPABLE;
      end
    end else begin
      // mid-sequence: lead with more to come, or intermediate continuation
      acc_nxt = cand;
      if (is_lead) begin
        seq_nxt = len;
        rem_nxt = len - 3'd1;
      end else begin
        rem_nxt = rem_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      seq_r <= '0;
      acc_r <= '0;
    end else if (adv) begin
      rem_r <= rem_nxt;
      seq_r <= seq_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

/* rtl/u8u16_obuf.sv */
// ----------------------------------------------------------------------------
// u8u16_obuf
// Result register holding up to two words; pops one word per handshake and
// takes a new group when it will be empty at the clock edge.
// ----------------------------------------------------------------------------
module u8u16_obuf
  import u8u16_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  dec_res_t         res,
  output logic             can_take,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [UnitW-1:0] out_tdata,
  output logic [StatW-1:0] out_tuser,
  output logic             out_tlast
);

  logic [1:0]       cnt_r;
  logic [UnitW-1:0] unit0_r;
  logic [StatW-1:0] stat0_r;
  logic             last0_r;
  logic [UnitW-1:0] unit1_r;
  logic             pop;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign can_take   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign out_tdata  = unit0_r;
  assign out_tuser  = stat0_r;
  assign out_tlast  = last0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= res.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit0_r <= res.unit0;
      stat0_r <= res.stat0;
      last0_r <= (res.cnt != 2'd2);
      unit1_r <= res.unit1;
    end else if (pop) begin
      unit0_r <= unit1_r;          // low surrogate moves up
      stat0_r <= ST_UNIT;
      last0_r <= 1'b1;
    end
  end

endmodule

/* rtl/utf8_to_utf16_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 transcoder, one byte per input word.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one UTF-8 byte per word in in_tdata[7:0].
//   out_* : one result word per UTF-16 unit or event. out_tdata is the code
//           unit (zero unless out_tuser is unit), out_tuser the status
//           (unit, end of string, bad lead, bad continuation, unmappable),
//           out_tlast marks the final word caused by one input byte.
//   Path: an accepted byte passes through the input register and then the
//           result register before its first result word shows.
//   Throughput: one byte per cycle when the result register can take it; a
//           supplementary code point gives two words, its last byte holding the
//           result register for both; the next byte waits in the input register.
//   Non-final sequence bytes and a byte order mark's last byte produce no word
//           but still pass through the result register slot, one per cycle.
//   Reset (rst_n low, synchronous): both registers empty, decoder expects a
//           lead byte.
//   Back-pressure: when out_tready is low the result register holds, the
//           input register fills, and in_tready stays low while it is full.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder
  import u8u16_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,    // [7:0] in_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [UnitW-1:0] out_tdata,   // [15:0] code_unit
  output logic [StatW-1:0] out_tuser,   // [2:0] status
  output logic             out_tlast    // last_of_run
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       can_take;
  logic       adv;
  dec_res_t   res;

  // held byte moves into the result register when that slot frees up
  assign adv       = in_vld_r && can_take;
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  u8u16_dec u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_byte (in_byte_r),
    .res     (res)
  );

  u8u16_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .res        (res),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
